>>> rtl/hcm_pkg.sv
// Package for the range/energy histogram with per-column mode table.
// Shared constants, request codes and the divider control struct.
package hcm_pkg;

  localparam int unsigned RANGE_COLUMNS_DEF = 1024;
  localparam int unsigned ENERGY_BINS_DEF   = 1024;
  localparam int unsigned COUNT_BITS_DEF    = 20;

  localparam logic [11:0] RANGE_W_RST  = 12'd64;
  localparam logic [11:0] ENERGY_W_RST = 12'd100;
  localparam logic [15:0] LIMIT_RST    = 16'd6400;

  // numerator/denominator widths of the shared divider
  localparam int unsigned DIV_NW = 48;
  localparam int unsigned DIV_DW = 20;

  typedef enum logic [1:0] {
    REQ_SCAN  = 2'd0,
    REQ_HIST  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NOP   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_RANGE_W  = 2'd0,
    CFG_ENERGY_W = 2'd1,
    CFG_LIMIT    = 2'd2
  } cfg_e;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

>>> rtl/hcm_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module hcm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

>>> rtl/hcm_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, unsigned.
// Uses hcm_pkg for widths and the control struct.
module hcm_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [hcm_pkg::DIV_NW-1:0] num_i,
  input  logic [hcm_pkg::DIV_DW-1:0] den_i,
  output hcm_pkg::div_ctl_t          ctl_o,
  output logic [hcm_pkg::DIV_NW-1:0] quo_o
);
  import hcm_pkg::*;

  localparam int unsigned CW = $clog2(DIV_NW + 1);

  logic [DIV_NW-1:0] quo_q, quo_d;
  logic [DIV_DW:0]   rem_q, rem_d;
  logic [DIV_DW-1:0] den_q, den_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW+1:0] diff;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DIV_DW-1:0], quo_q[DIV_NW-1]};
    diff   = {1'b0, trial} - {2'b00, den_q};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CW'(DIV_NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[DIV_DW+1]) begin
        rem_d = diff[DIV_DW:0];
        quo_d = {quo_q[DIV_NW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[DIV_NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quo_o       = quo_q;
  assign ctl_o.start = start_i;
  assign ctl_o.busy  = busy_q;
  assign ctl_o.done  = done_q;
endmodule

>>> rtl/histogram_column_mode_table_top.sv
// Range/energy 2D histogram with a per-column mode table, top level.
// Depends on hcm_pkg, hcm_div and hcm_ram.
//
// Input words (req_type, range_value, energy_value, column) arrive on
// in_valid_i/in_stall_o; one result word leaves on out_valid_o/out_stall_i
// for every input word. Scan words update min/max, histogram words bin the
// sample and bump a counter cell, query words read the column mode table.
// Each histogram word runs four divisions (bin count and bin index for range
// and energy) on the one shared bit-serial divider, then a counter
// read-modify-write that is skipped when the sample is dropped. Scan and
// no-op words go straight to ST_OUT, queries pass ST_QRD and ST_QMUL first
// (one RAM read plus a latch step). The next word can be taken once the
// receiver has the result. The block takes a single word at a time;
// in_stall_o is high while it works and while a result waits for the
// receiver. After reset the counter and mode RAMs are swept to zero, one
// entry per cycle, covering all 2^(clog2(RANGE_COLUMNS)+clog2(ENERGY_BINS))
// counter entries (1M by default), during which no input word is taken.
// Config writes are accepted at any time.
// A stalled result holds; the next word is taken once it has gone.
module histogram_column_mode_table_top #(
  parameter int unsigned RANGE_COLUMNS = hcm_pkg::RANGE_COLUMNS_DEF,
  parameter int unsigned ENERGY_BINS   = hcm_pkg::ENERGY_BINS_DEF,
  parameter int unsigned COUNT_BITS    = hcm_pkg::COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] range_value_i,
  input  logic [15:0] energy_value_i,
  input  logic [9:0]  column_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic        dropped_o,
  output logic [16:0] range_low_o,
  output logic [17:0] energy_mid_o,
  output logic [19:0] mode_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import hcm_pkg::*;

  localparam int unsigned CB    = $clog2(RANGE_COLUMNS);
  localparam int unsigned EB    = $clog2(ENERGY_BINS);
  localparam int unsigned AB    = CB + EB;
  localparam int unsigned DEPTH = 1 << AB;
  localparam int unsigned CDEPTH = 1 << CB;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  typedef enum logic [11:0] {
    ST_CLEAR = 12'b000000000001,
    ST_IDLE  = 12'b000000000010,
    ST_NR    = 12'b000000000100,
    ST_BR    = 12'b000000001000,
    ST_NE    = 12'b000000010000,
    ST_BE    = 12'b000000100000,
    ST_CHK   = 12'b000001000000,
    ST_RD    = 12'b000010000000,
    ST_UPD   = 12'b000100000000,
    ST_QRD   = 12'b001000000000,
    ST_QMUL  = 12'b010000000000,
    ST_OUT   = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  logic [11:0] wr_q, we_q;
  logic [15:0] lim_q;
  logic [15:0] rlo_q, rhi_q, elo_q, ehi_q;
  logic        first_q;
  logic [AB:0] clr_q;

  logic [1:0]  req_q;
  logic [15:0] rv_q, ev_q;
  logic [9:0]  col_q;
  logic [19:0] nb_q;          // bin count from the first (range) or third (energy) division
  logic [47:0] rb_q, eb_q;    // raw bin quotients
  logic        rneg_q, eneg_q;
  logic        bneg_q;

  logic        found_q, dropped_q, ovalid_q;
  logic [16:0] rlow_q;
  logic [17:0] emid_q;
  logic [19:0] mcnt_q;

  logic [11:0] wr_e, we_e;
  assign wr_e = (wr_q == '0) ? 12'd1 : wr_q;
  assign we_e = (we_q == '0) ? 12'd1 : we_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= RANGE_W_RST;
      we_q  <= ENERGY_W_RST;
      lim_q <= LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RANGE_W:  wr_q  <= cfg_data_i[11:0];
        CFG_ENERGY_W: we_q  <= cfg_data_i[11:0];
        CFG_LIMIT:    lim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // span per axis, clamped to at least 1 (cannot go below 1 unless min>max)
  logic        is_range;
  logic [15:0] lo_s, hi_s, v_s;
  logic [11:0] w_s;
  logic [17:0] span_raw;
  logic [17:0] span;
  assign is_range = (state_q == ST_NR) || (state_q == ST_BR);
  assign lo_s = is_range ? rlo_q : elo_q;
  assign hi_s = is_range ? rhi_q : ehi_q;
  assign v_s  = is_range ? rv_q : ev_q;
  assign w_s  = is_range ? wr_e : we_e;
  assign span_raw = {2'b00, hi_s} - {2'b00, lo_s} + {6'd0, w_s};
  assign span = (span_raw[17] || span_raw == '0) ? 18'd1 : span_raw;

  // numerator of the bin division: 2*N*|d| +- span, sign kept apart
  logic        d_neg;
  logic [16:0] d_mag;
  logic [37:0] prod;
  logic [47:0] bnum;
  logic        bneg;
  assign d_neg = v_s < lo_s;
  assign d_mag = d_neg ? {1'b0, lo_s - v_s} : {1'b0, v_s - lo_s};
  assign prod  = {nb_q, 1'b0} * d_mag;
  always_comb begin
    bneg = 1'b0;
    if (!d_neg) begin
      bnum = {10'd0, prod} + {30'd0, span};
    end else if ({10'd0, prod} <= {30'd0, span}) begin
      bnum = {30'd0, span} - {10'd0, prod};    // result is 0
    end else begin
      bneg = 1'b1;
      // floor of negative: -(ceil((P-S)/2S)); only sign matters here
      bnum = {10'd0, prod} - {30'd0, span};
    end
  end

  logic        div_start;
  logic [47:0] div_num;
  logic [19:0] div_den;
  div_ctl_t    div_ctl;
  logic [47:0] div_quo;

  hcm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .ctl_o  (div_ctl),
    .quo_o  (div_quo)
  );

  logic go_q;  // divider issued for the current state
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    if (!go_q) begin
      case (state_q)
        ST_NR, ST_NE: begin
          div_start = 1'b1;
          div_num   = {29'd0, span, 1'b0} + {36'd0, w_s};
          div_den   = {7'd0, w_s, 1'b0};
        end
        ST_BR, ST_BE: begin
          div_start = 1'b1;
          div_num   = bnum;
          div_den   = {1'b0, span, 1'b0};
        end
        default: ;
      endcase
    end
  end

  // memories
  logic [AB-1:0]         cnt_addr;
  logic                  cnt_we;
  logic [COUNT_BITS-1:0] cnt_wd, cnt_rd;
  logic [CB-1:0]         col_addr;
  logic                  col_we;
  logic [EB+COUNT_BITS-1:0] col_wd, col_rd;

  hcm_ram #(.Width(COUNT_BITS), .Depth(DEPTH)) u_cnt_ram (
    .clk_i(clk_i), .we_i(cnt_we), .addr_i(cnt_addr), .wdata_i(cnt_wd), .rdata_o(cnt_rd)
  );
  hcm_ram #(.Width(EB + COUNT_BITS), .Depth(CDEPTH)) u_col_ram (
    .clk_i(clk_i), .we_i(col_we), .addr_i(col_addr), .wdata_i(col_wd), .rdata_o(col_rd)
  );

  logic          in_range;
  logic [CB-1:0] rbin;
  logic [EB-1:0] ebin;
  assign in_range = !rneg_q && !eneg_q && (rb_q < 48'(RANGE_COLUMNS))
                    && (eb_q < 48'(ENERGY_BINS));
  assign rbin = rb_q[CB-1:0];
  assign ebin = eb_q[EB-1:0];

  logic [COUNT_BITS-1:0] n_inc, best_cnt;
  logic [EB-1:0]         best_bin;
  logic                  better;
  assign n_inc    = (cnt_rd == CMAX) ? cnt_rd : cnt_rd + 1'b1;
  assign best_cnt = col_rd[COUNT_BITS-1:0];
  assign best_bin = col_rd[EB+COUNT_BITS-1:COUNT_BITS];
  assign better   = (n_inc > best_cnt) || ((n_inc == best_cnt) && (ebin < best_bin));

  logic col_ok;
  assign col_ok = ({22'd0, col_q} < 32'(RANGE_COLUMNS));

  always_comb begin
    cnt_addr = {rbin, ebin};
    cnt_we   = 1'b0;
    cnt_wd   = n_inc;
    col_addr = (state_q == ST_QRD) ? CB'(col_q) : rbin;
    col_we   = 1'b0;
    col_wd   = {ebin, n_inc};
    case (state_q)
      ST_CLEAR: begin
        cnt_addr = clr_q[AB-1:0];
        cnt_we   = 1'b1;
        cnt_wd   = '0;
        col_addr = clr_q[CB-1:0];
        col_we   = 1'b1;
        col_wd   = '0;
      end
      ST_UPD: begin
        cnt_we = 1'b1;
        col_we = better;
      end
      default: ;
    endcase
  end

  logic in_acc;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE) || ovalid_q;

  // query arithmetic
  logic [EB-1:0]         best_bin_r;
  logic [11:0]           best_bin_q;
  logic [COUNT_BITS-1:0] qcnt_q;
  logic [31:0] rlow_w;
  logic [33:0] elow_w;
  assign rlow_w = {22'd0, col_q} * {20'd0, wr_e} + {16'd0, rlo_q};
  assign elow_w = {22'd0, best_bin_q} * {22'd0, we_e};
  assign best_bin_r = best_bin;

  logic [34:0] emid_w;
  logic [33:0] r2;
  assign emid_w = {1'b0, elow_w} + {19'd0, elo_q} + {23'd0, we_e[11:1]};
  assign r2 = {1'b0, rlow_w, 1'b0} + {22'd0, wr_e};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == (AB+1)'(DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          case (req_e'(req_type_i))
            REQ_HIST:  state_d = ST_NR;
            REQ_QUERY: state_d = ST_QRD;
            default:   state_d = ST_OUT;
          endcase
        end
      end
      ST_NR:   if (div_ctl.done) state_d = ST_BR;
      ST_BR:   if (div_ctl.done) state_d = ST_NE;
      ST_NE:   if (div_ctl.done) state_d = ST_BE;
      ST_BE:   if (div_ctl.done) state_d = ST_CHK;
      ST_CHK:  state_d = in_range ? ST_RD : ST_OUT;
      ST_RD:   state_d = ST_UPD;
      ST_UPD:  state_d = ST_OUT;
      ST_QRD:  state_d = ST_QMUL;
      ST_QMUL: state_d = ST_OUT;
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      go_q     <= 1'b0;
      ovalid_q <= 1'b0;
      first_q  <= 1'b1;
      rlo_q    <= '0;
      rhi_q    <= '0;
      elo_q    <= '0;
      ehi_q    <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (div_start) go_q <= 1'b1;
      else if (div_ctl.done) go_q <= 1'b0;
      if (state_q == ST_OUT) ovalid_q <= 1'b1;
      else if (!out_stall_i) ovalid_q <= 1'b0;
      if (in_acc && req_e'(req_type_i) == REQ_SCAN) begin
        if (first_q) begin
          rlo_q <= range_value_i; rhi_q <= range_value_i;
          elo_q <= energy_value_i; ehi_q <= energy_value_i;
          first_q <= 1'b0;
        end else begin
          if (range_value_i < rlo_q) rlo_q <= range_value_i;
          if (range_value_i > rhi_q) rhi_q <= range_value_i;
          if (energy_value_i < elo_q) elo_q <= energy_value_i;
          if (energy_value_i > ehi_q) ehi_q <= energy_value_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q     <= req_type_i;
      rv_q      <= range_value_i;
      ev_q      <= energy_value_i;
      col_q     <= column_i;
      found_q   <= 1'b0;
      dropped_q <= 1'b0;
      rlow_q    <= '0;
      emid_q    <= '0;
      mcnt_q    <= '0;
    end
    if (div_ctl.done) begin
      case (state_q)
        ST_NR, ST_NE: nb_q <= div_quo[19:0];
        ST_BR: begin rb_q <= div_quo; rneg_q <= bneg_q; end
        ST_BE: begin eb_q <= div_quo; eneg_q <= bneg_q; end
        default: ;
      endcase
    end
    if (state_q == ST_CHK && !in_range) dropped_q <= 1'b1;
    if (state_q == ST_QRD) begin
      qcnt_q     <= '0;
      best_bin_q <= '0;
    end
    if (state_q == ST_QMUL) begin
      qcnt_q     <= col_ok ? best_cnt : '0;
      best_bin_q <= col_ok ? 12'(best_bin_r) : '0;
    end
    if (state_q == ST_OUT && req_e'(req_q) == REQ_QUERY) begin
      rlow_q <= (rlow_w > 32'd131071) ? 17'h1FFFF : rlow_w[16:0];
      if (qcnt_q != '0) begin
        emid_q  <= (emid_w > 35'd262143) ? 18'h3FFFF : emid_w[17:0];
        mcnt_q  <= (32'(qcnt_q) > 32'd1048575) ? 20'hFFFFF : 20'(qcnt_q);
        found_q <= r2 < {17'd0, lim_q, 1'b0};
      end
    end
  end

  // sign of the bin division latched at issue time
  always_ff @(posedge clk_i) begin
    if (div_start) bneg_q <= bneg;
  end

  assign out_valid_o  = ovalid_q;
  assign found_o      = found_q;
  assign dropped_o    = dropped_q;
  assign range_low_o  = rlow_q;
  assign energy_mid_o = emid_q;
  assign mode_count_o = mcnt_q;

  // one word in flight: no new word while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni) ovalid_q |-> in_stall_o)
    else $error("input taken while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_acc)
    else $error("input taken during clear sweep");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && out_stall_i) |=> ovalid_q)
    else $error("stalled result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl.start |-> !div_ctl.busy)
    else $error("divider restarted while busy");
endmodule
